/* hw/rtl/iems_pkg.sv */
// types and constants shared by the i2c eeprom master sequencer
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package iems_pkg;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_WORD_ADDRESS   = 2'd1;
  localparam logic [1:0] REG_WRITE_DATA     = 2'd2;

  // register values after reset
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h50;
  localparam logic [7:0] WORD_ADDRESS_RESET   = 8'hAA;
  localparam logic [7:0] WRITE_DATA_RESET     = 8'h55;

  typedef struct packed {
    logic [1:0] mode;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] read_byte;
    logic       read_matches;
  } res_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } cfg_t;

  // current register contents handed to the sequencer
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] word_address;
    logic [7:0] write_data;
  } regs_t;

endpackage

`default_nettype wire

/* hw/rtl/iems_chan_if.sv */
// valid/ready channel carrying one payload per transaction
// payload type is given by the instantiating level, usually from iems_pkg
`timescale 1ns / 1ps
`default_nettype none

interface iems_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/i2c_eeprom_master_sequencer_top.sv */
// top level of the i2c eeprom master sequencer: config registers, sequencer, result buffer
// depends on iems_pkg, iems_chan_if and iems_core
`timescale 1ns / 1ps
`default_nettype none

// channel  role    payload                                    transaction
// cfg      sink    index[1:0], data[7:0]                      register write
// cmd      sink    mode[1:0], sda_sample                      one tick or command
// result   source  scl_level, sda_release, busy_res, done_res,
//                  nack_seen, read_byte[7:0], read_matches    one per cmd transaction
//
// one cmd transaction per clock while cmd.ready is high; the sequencer state and the
// result are updated at the accepting edge (result into the output register or skid)
// results sit in an output register backed by one skid entry; cmd stalls only
// when both are full
// rst is synchronous: bus released high, sequencer idle, registers to defaults
// cfg is always ready; write it only while the sequencer is idle (not enforced here)

module i2c_eeprom_master_sequencer_top (
  input wire logic clk,
  input wire logic rst,
  iems_chan_if.sink   cfg,
  iems_chan_if.sink   cmd,
  iems_chan_if.source result
);
  import iems_pkg::*;

  regs_t regs;
  res_t  res_next;
  res_t  out_data, skid_data;
  logic  out_valid, skid_valid;
  logic  accept, take;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.device_address <= DEVICE_ADDRESS_RESET;
      regs.word_address   <= WORD_ADDRESS_RESET;
      regs.write_data     <= WRITE_DATA_RESET;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_DEVICE_ADDRESS: regs.device_address <= cfg.payload.data[6:0];
        REG_WORD_ADDRESS:   regs.word_address   <= cfg.payload.data;
        REG_WRITE_DATA:     regs.write_data     <= cfg.payload.data;
        default:            regs                <= regs;
      endcase
    end
  end

  // command side advances the sequencer once per transaction
  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign take      = result.valid && result.ready;

  iems_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (accept),
    .cmd      (cmd.payload),
    .regs     (regs),
    .res_next (res_next)
  );

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !take) begin
        // downstream stalled: park the new result
        skid_valid <= 1'b1;
        skid_data  <= res_next;
      end else begin
        out_valid <= 1'b1;
        out_data  <= res_next;
      end
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  // skid entry is only ever filled behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // a full buffer that is not drained stays full and stalls the command side
  a_full_stalls : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take) |=> (skid_valid && !cmd.ready))
    else $error("full result buffer lost an entry or accepted a command");

  // the done pulse always ends the transaction
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done result reported while still busy");

  // a read match is only reported together with done
  a_match_on_done : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_matches) |-> out_data.done_res)
    else $error("read match reported outside the done result");

endmodule

`default_nettype wire

/* hw/rtl/iems_core.sv */
// bit sequencer: quarter-bit phase, step, shifters and the driven bus levels
// uses iems_pkg types; stepped once per accepted command transaction
`timescale 1ns / 1ps
`default_nettype none

module iems_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step_en,
  input  wire iems_pkg::cmd_t  cmd,
  input  wire iems_pkg::regs_t regs,
  output iems_pkg::res_t       res_next
);
  import iems_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_DEVW   = 4'd2;
  localparam logic [3:0] ST_ACK1   = 4'd3;
  localparam logic [3:0] ST_WADDR  = 4'd4;
  localparam logic [3:0] ST_ACK2   = 4'd5;
  localparam logic [3:0] ST_DATA   = 4'd6;
  localparam logic [3:0] ST_ACK3   = 4'd7;
  localparam logic [3:0] ST_STOP   = 4'd8;
  localparam logic [3:0] ST_RSTART = 4'd9;
  localparam logic [3:0] ST_DEVR   = 4'd10;
  localparam logic [3:0] ST_ACK4   = 4'd11;
  localparam logic [3:0] ST_RECV   = 4'd12;
  localparam logic [3:0] ST_MNACK  = 4'd13;

  logic [1:0] quarter_phase, quarter_phase_next;
  logic [2:0] bit_position, bit_position_next;
  logic [3:0] state, state_next;
  logic [7:0] tx_shift, tx_shift_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic       is_read_op, is_read_op_next;
  logic       active, active_next;
  logic       sticky_nack, sticky_nack_next;
  logic       scl_drv, scl_drv_next;
  logic       sda_drv, sda_drv_next;

  logic       is_send, is_ack, scl_high;
  logic       done, read_match;
  logic [3:0] follow;

  assign is_send  = (state == ST_DEVW) || (state == ST_WADDR) ||
                    (state == ST_DATA) || (state == ST_DEVR);
  assign is_ack   = (state == ST_ACK1) || (state == ST_ACK2) ||
                    (state == ST_ACK3) || (state == ST_ACK4);
  assign scl_high = (quarter_phase == 2'd1) || (quarter_phase == 2'd2);

  // step order; the second ack splits write and read
  always_comb begin
    case (state)
      ST_START:  follow = ST_DEVW;
      ST_DEVW:   follow = ST_ACK1;
      ST_ACK1:   follow = ST_WADDR;
      ST_WADDR:  follow = ST_ACK2;
      ST_ACK2:   follow = is_read_op ? ST_RSTART : ST_DATA;
      ST_DATA:   follow = ST_ACK3;
      ST_ACK3:   follow = ST_STOP;
      ST_RSTART: follow = ST_DEVR;
      ST_DEVR:   follow = ST_ACK4;
      ST_ACK4:   follow = ST_RECV;
      ST_RECV:   follow = ST_MNACK;
      ST_MNACK:  follow = ST_STOP;
      default:   follow = ST_IDLE;
    endcase
  end

  always_comb begin
    quarter_phase_next = quarter_phase;
    bit_position_next  = bit_position;
    state_next         = state;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    is_read_op_next    = is_read_op;
    active_next        = active;
    sticky_nack_next   = sticky_nack;
    scl_drv_next       = scl_drv;
    sda_drv_next       = sda_drv;
    done               = 1'b0;
    read_match         = 1'b0;

    if (((cmd.mode == MODE_WRITE) || (cmd.mode == MODE_READ)) && !active) begin
      // command start: nothing new on the bus yet
      active_next        = 1'b1;
      is_read_op_next    = (cmd.mode == MODE_READ);
      state_next         = ST_START;
      quarter_phase_next = 2'd0;
      bit_position_next  = 3'd0;
      sticky_nack_next   = 1'b0;
      if (cmd.mode == MODE_READ) begin
        rx_shift_next = 8'd0;
      end
    end else if ((cmd.mode == MODE_TICK) && active) begin
      case (state) inside
        ST_START, ST_RSTART: begin
          scl_drv_next = scl_high;
          sda_drv_next = !quarter_phase[1];
        end
        ST_STOP: begin
          scl_drv_next = (quarter_phase != 2'd0);
          sda_drv_next = quarter_phase[1];
        end
        ST_DEVW, ST_WADDR, ST_DATA, ST_DEVR: begin
          scl_drv_next = scl_high;
          sda_drv_next = tx_shift[7];
        end
        default: begin
          scl_drv_next = scl_high;
          sda_drv_next = 1'b1;
        end
      endcase

      // sample point, second high quarter
      if (quarter_phase == 2'd2) begin
        if (is_ack && cmd.sda_sample) begin
          sticky_nack_next = 1'b1;
        end
        if (state == ST_RECV) begin
          rx_shift_next = {rx_shift[6:0], cmd.sda_sample};
        end
      end

      // end of the bit slot
      if (quarter_phase == 2'd3) begin
        if (is_send) begin
          tx_shift_next = {tx_shift[6:0], 1'b0};
        end
        if ((is_send || (state == ST_RECV)) && (bit_position != 3'd7)) begin
          bit_position_next = bit_position + 3'd1;
        end else begin
          bit_position_next = 3'd0;
          if (state == ST_STOP) begin
            done        = 1'b1;
            read_match  = is_read_op && (rx_shift == regs.write_data);
            active_next = 1'b0;
            state_next  = ST_IDLE;
          end else begin
            state_next = follow;
            case (follow)
              ST_DEVW:  tx_shift_next = {regs.device_address, 1'b0};
              ST_WADDR: tx_shift_next = regs.word_address;
              ST_DATA:  tx_shift_next = regs.write_data;
              ST_DEVR:  tx_shift_next = {regs.device_address, 1'b1};
              default:  tx_shift_next = tx_shift_next;
            endcase
            if (follow == ST_IDLE) begin
              active_next = 1'b0;
            end
          end
        end
      end
      quarter_phase_next = quarter_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_phase <= 2'd0;
      bit_position  <= 3'd0;
      state         <= ST_IDLE;
      tx_shift      <= 8'd0;
      rx_shift      <= 8'd0;
      is_read_op    <= 1'b0;
      active        <= 1'b0;
      sticky_nack   <= 1'b0;
      scl_drv       <= 1'b1;
      sda_drv       <= 1'b1;
    end else if (step_en) begin
      quarter_phase <= quarter_phase_next;
      bit_position  <= bit_position_next;
      state         <= state_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      is_read_op    <= is_read_op_next;
      active        <= active_next;
      sticky_nack   <= sticky_nack_next;
      scl_drv       <= scl_drv_next;
      sda_drv       <= sda_drv_next;
    end
  end

  assign res_next = '{
    scl_level:    scl_drv_next,
    sda_release:  sda_drv_next,
    busy_res:     active_next,
    done_res:     done,
    nack_seen:    sticky_nack_next,
    read_byte:    rx_shift_next,
    read_matches: read_match
  };

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for i2c_eeprom_master_sequencer_top: a scoreboard class
// tracks the quarter-bit i2c sequence and checks every result field by field
// depends on iems_pkg, iems_chan_if and the rtl top level
`timescale 1ns / 1ps

import iems_pkg::*;

typedef enum logic [3:0] {
  STEP_IDLE, STEP_START, STEP_DEVW, STEP_ACK1, STEP_WADDR, STEP_ACK2, STEP_DATA,
  STEP_ACK3, STEP_STOP, STEP_RSTART, STEP_DEVR, STEP_ACK4, STEP_RECV, STEP_MNACK
} seq_step_t;

class eeprom_scoreboard;
  res_t        expected_q[$];
  int unsigned failures, checked, n_writes, n_reads, n_matched, n_nacked;
  // register copy
  logic [6:0]  dev_addr;
  logic [7:0]  word_addr;
  logic [7:0]  wr_data;
  // sequencer copy
  logic [1:0]  phase;
  logic [3:0]  bit_idx;
  seq_step_t   step;
  logic [7:0]  tx_sh;
  logic [7:0]  rx_sh;
  bit          read_op, running, nack_flag;
  logic        scl_q, sda_q;

  function new();
    dev_addr  = DEVICE_ADDRESS_RESET;
    word_addr = WORD_ADDRESS_RESET;
    wr_data   = WRITE_DATA_RESET;
    phase     = '0;
    bit_idx   = '0;
    step      = STEP_IDLE;
    tx_sh     = '0;
    rx_sh     = '0;
    read_op   = 0;
    running   = 0;
    nack_flag = 0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
  endfunction

  function bit is_send(seq_step_t s);
    return s inside {STEP_DEVW, STEP_WADDR, STEP_DATA, STEP_DEVR};
  endfunction

  function bit is_ack(seq_step_t s);
    return s inside {STEP_ACK1, STEP_ACK2, STEP_ACK3, STEP_ACK4};
  endfunction

  function seq_step_t next_step(seq_step_t s);
    case (s)
      STEP_START:  return STEP_DEVW;
      STEP_DEVW:   return STEP_ACK1;
      STEP_ACK1:   return STEP_WADDR;
      STEP_WADDR:  return STEP_ACK2;
      STEP_ACK2:   return read_op ? STEP_RSTART : STEP_DATA;
      STEP_DATA:   return STEP_ACK3;
      STEP_ACK3:   return STEP_STOP;
      STEP_RSTART: return STEP_DEVR;
      STEP_DEVR:   return STEP_ACK4;
      STEP_ACK4:   return STEP_RECV;
      STEP_RECV:   return STEP_MNACK;
      STEP_MNACK:  return STEP_STOP;
      default:     return STEP_IDLE;
    endcase
  endfunction

  function void load_step(seq_step_t s);
    step = s;
    case (s)
      STEP_DEVW:  tx_sh = {dev_addr, 1'b0};
      STEP_WADDR: tx_sh = word_addr;
      STEP_DATA:  tx_sh = wr_data;
      STEP_DEVR:  tx_sh = {dev_addr, 1'b1};
      default: ;
    endcase
  endfunction

  function void note_config(logic [1:0] idx, logic [7:0] val);
    case (idx)
      REG_DEVICE_ADDRESS: dev_addr = val[6:0];
      REG_WORD_ADDRESS:   word_addr = val;
      REG_WRITE_DATA:     wr_data = val;
      default: ;
    endcase
  endfunction

  // advances the copy by one command and queues its result; returns 1 if it did anything
  function bit note_command(cmd_t c);
    res_t      r;
    logic [1:0] q;
    seq_step_t s;
    logic      hi;
    bit        effect;
    r = '0;
    effect = 0;
    if ((c.mode == MODE_WRITE || c.mode == MODE_READ) && !running) begin
      effect    = 1;
      running   = 1;
      read_op   = (c.mode == MODE_READ);
      step      = STEP_START;
      phase     = '0;
      bit_idx   = '0;
      nack_flag = 0;
      if (read_op) rx_sh = '0;
    end else if (c.mode == MODE_TICK && running) begin
      effect = 1;
      s  = step;
      q  = phase;
      hi = (q == 2'd1 || q == 2'd2);
      case (s)
        STEP_START, STEP_RSTART: begin
          scl_q = hi;
          sda_q = (q < 2'd2);
        end
        STEP_STOP: begin
          scl_q = (q != 2'd0);
          sda_q = (q >= 2'd2);
        end
        STEP_DEVW, STEP_WADDR, STEP_DATA, STEP_DEVR: begin
          scl_q = hi;
          sda_q = tx_sh[7];
        end
        default: begin
          scl_q = hi;
          sda_q = 1'b1;
        end
      endcase
      if (q == 2'd2) begin
        if (is_ack(s) && c.sda_sample) nack_flag = 1;
        if (s == STEP_RECV) rx_sh = {rx_sh[6:0], c.sda_sample};
      end
      if (q == 2'd3) begin
        if (is_send(s)) tx_sh = tx_sh << 1;
        if ((is_send(s) || s == STEP_RECV) && bit_idx < 4'd7) begin
          bit_idx++;
        end else begin
          bit_idx = '0;
          if (s == STEP_STOP) begin
            r.done_res     = 1'b1;
            r.read_matches = read_op && (rx_sh == wr_data);
            running = 0;
            step    = STEP_IDLE;
            if (read_op) n_reads++;
            else n_writes++;
            if (r.read_matches) n_matched++;
            if (nack_flag) n_nacked++;
          end else begin
            load_step(next_step(s));
            if (step == STEP_IDLE) running = 0;
          end
        end
      end
      phase = q + 2'd1;
    end
    r.scl_level   = scl_q;
    r.sda_release = sda_q;
    r.busy_res    = running;
    r.nack_seen   = nack_flag;
    r.read_byte   = rx_sh;
    expected_q.push_back(r);
    return effect;
  endfunction

  function void diff(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      failures++;
      if (failures <= 40)
        $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 40)
        $display("%0t: result with nothing expected, expected none actual %p", $time, got);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    diff("scl_level", want.scl_level, got.scl_level);
    diff("sda_release", want.sda_release, got.sda_release);
    diff("busy_res", want.busy_res, got.busy_res);
    diff("done_res", want.done_res, got.done_res);
    diff("nack_seen", want.nack_seen, got.nack_seen);
    diff("read_byte", want.read_byte, got.read_byte);
    diff("read_matches", want.read_matches, got.read_matches);
  endfunction
endclass

module tb;
  // mode three has no name in the package: it does nothing
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;

  iems_chan_if #(.payload_t(cfg_t)) cfg_ch ();
  iems_chan_if #(.payload_t(cmd_t)) cmd_ch ();
  iems_chan_if #(.payload_t(res_t)) res_ch ();

  i2c_eeprom_master_sequencer_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .cmd    (cmd_ch),
    .result (res_ch)
  );

  eeprom_scoreboard sb = new();

  bit          no_gaps;       // long stretch with both sides always willing
  bit          pause_pending; // one mid-sequence drain of the result queue
  int unsigned useful_items;
  int unsigned cycle_count;

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result sink: ready is low about 12 percent of the time unless gaps are off
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= no_gaps || ($urandom_range(99) >= 12);
    end
  end

  // every accepted result goes to the scoreboard; sampled values are pre-edge
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
  end

  // sends one command transaction, with a random gap in front of it
  // valid is left high after acceptance so back-to-back transactions never toggle it
  task automatic send_cmd(input cmd_t c);
    while (!no_gaps && $urandom_range(99) < 12) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    if (sb.note_command(c)) useful_items++;
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // writes all three registers back to back, only called with the sequencer idle
  task automatic load_regs(input logic [6:0] dev, input logic [7:0] waddr,
                           input logic [7:0] wdata);
    cfg_t w[3];
    w[0] = '{index: REG_DEVICE_ADDRESS, data: {1'b0, dev}};
    w[1] = '{index: REG_WORD_ADDRESS, data: waddr};
    w[2] = '{index: REG_WRITE_DATA, data: wdata};
    foreach (w[i]) begin
      cfg_ch.valid   <= 1'b1;
      cfg_ch.payload <= w[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.note_config(w[i].index, w[i].data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // data line level for the next tick: the slave's ack and read bits matter only in quarter 2
  function automatic logic pick_sda(logic [7:0] rx_target, int unsigned nack_pct);
    if (sb.phase != 2'd2) return 1'($urandom);
    if (sb.is_ack(sb.step)) return $urandom_range(99) < nack_pct;
    if (sb.step == STEP_RECV) return rx_target[3'd7 - sb.bit_idx[2:0]];
    return 1'($urandom);
  endfunction

  // ticks the current operation to its stop, sprinkling ignored commands in
  task automatic finish_op(input logic [7:0] rx_target, input int unsigned nack_pct,
                           input int unsigned noise_pct);
    cmd_t c;
    while (sb.running) begin
      if (pause_pending && sb.step == STEP_WADDR) begin
        pause_pending = 0;
        drain();
      end
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: c.mode = MODE_WRITE;
          1: c.mode = MODE_READ;
          default: c.mode = MODE_NOP;
        endcase
        c.sda_sample = 1'($urandom);
      end else begin
        c.mode       = MODE_TICK;
        c.sda_sample = pick_sda(rx_target, nack_pct);
      end
      send_cmd(c);
    end
  endtask

  task automatic run_op(input bit is_read, input logic [7:0] rx_target,
                        input int unsigned nack_pct, input int unsigned noise_pct);
    send_cmd('{mode: is_read ? MODE_READ : MODE_WRITE, sda_sample: 1'($urandom)});
    finish_op(rx_target, nack_pct, noise_pct);
  endtask

  // timeout watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, sb.expected_q.size());
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned phase_idx;
    int unsigned nack_pct;
    logic [7:0]  rx_target;
    rst            <= 1'b1;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    no_gaps        = 0;
    pause_pending  = 0;
    useful_items   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle ticks and mode three leave the bus released
    send_cmd('{mode: MODE_TICK, sda_sample: 1'b0});
    send_cmd('{mode: MODE_TICK, sda_sample: 1'b1});
    send_cmd('{mode: MODE_NOP, sda_sample: 1'b1});
    // byte write with commands and mode three thrown at it while busy
    send_cmd('{mode: MODE_WRITE, sda_sample: 1'b0});
    repeat (6) send_cmd('{mode: MODE_TICK, sda_sample: 1'b0});
    send_cmd('{mode: MODE_WRITE, sda_sample: 1'b1});
    send_cmd('{mode: MODE_READ, sda_sample: 1'b0});
    send_cmd('{mode: MODE_NOP, sda_sample: 1'b0});
    // every ack slot reads high, so the sticky nack must show
    finish_op(8'h00, 100, 0);
    // clean random read returning the write data: nack cleared, match reported
    run_op(1'b1, WRITE_DATA_RESET, 0, 0);
    // read of all ones with missing acks: shifter cleared first, no match
    run_op(1'b1, 8'hFF, 100, 0);

    // random phases, each starting from an idle sequencer with fresh registers
    pause_pending = 1;
    phase_idx = 0;
    while (useful_items < RANDOM_ITEMS) begin
      drain();
      case (phase_idx)
        0: load_regs(7'h00, 8'h00, 8'h00);
        1: load_regs(7'h7F, 8'hFF, 8'hFF);
        default: load_regs(7'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // first phase runs with no idling on either side
      no_gaps = (phase_idx == 0);
      repeat (3) begin
        // a little idle noise between operations
        repeat ($urandom_range(2)) begin
          send_cmd('{mode: $urandom_range(1) ? MODE_TICK : MODE_NOP,
                     sda_sample: 1'($urandom)});
        end
        nack_pct  = ($urandom_range(99) < 70) ? 0 : 30;
        rx_target = $urandom_range(1) ? sb.wr_data : 8'($urandom);
        run_op(1'($urandom), rx_target, nack_pct, 4);
      end
      phase_idx++;
    end
    no_gaps = 0;

    // wait for the last results, then keep watching for anything spurious
    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d byte writes and %0d random reads (%0d read back the write data)",
             sb.n_writes, sb.n_reads, sb.n_matched);
    $display("%0d operations saw a missing ack, %0d results checked over %0d cycles",
             sb.n_nacked, sb.checked, cycle_count);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
